FILE: src/fcr_pkg.sv
// Shared widths and constants for the filled circle rectangle rasterizer.
// No dependencies; imported by fcr_isqrt and the top level.
`default_nettype none

package fcr_pkg;

    localparam int RAD_W   = 6;   // radius and root width
    localparam int SQ_W    = 12;  // squared radius width
    localparam int BIT_W   = 3;   // root bit index width
    localparam int CX_W    = 10;  // center coordinate width
    localparam int COORD_W = 12;  // output coordinate width
    localparam int COLOR_W = 16;
    localparam int KPROD_W = 22;  // radius * 1/sqrt(2), a Q6.16 product of the Q0.16 constant

    localparam logic [KPROD_W-1:0] INV_SQRT2_Q16 = KPROD_W'(46341);

endpackage

`default_nettype wire

FILE: src/fcr_isqrt.sv
// Iterative integer square root, one result bit per cycle (floor).
// Depends on fcr_pkg.
`default_nettype none

module fcr_isqrt
    import fcr_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [SQ_W-1:0] radicand,
    output logic                 done,
    output logic [RAD_W-1:0]     root
);

    logic              busy_reg;
    logic              done_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic [RAD_W-1:0]  root_reg;
    logic [SQ_W-1:0]   rad_reg;
    logic [RAD_W-1:0]  trial;
    logic [SQ_W-1:0]   trial_sq;

    // shared trial multiply: try setting the current bit
    assign trial    = root_reg | (RAD_W'(1) << bit_reg);
    assign trial_sq = SQ_W'(trial) * SQ_W'(trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                bit_reg  <= BIT_W'(RAD_W - 1);
                root_reg <= '0;
                rad_reg  <= radicand;
            end else if (busy_reg) begin
                if (trial_sq <= rad_reg) begin
                    root_reg <= trial;
                end
                if (bit_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    done_reg <= 1'b0;
                    bit_reg  <= bit_reg - BIT_W'(1);
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

FILE: src/filled_circle_rect_rasterizer_unit.sv
// Filled circle rasterizer: one circle command in, a run of filled rectangles out.
// Depends on fcr_pkg and fcr_isqrt.
//
//  channel | ports               | tdata fields, lowest bit up
//  --------+---------------------+----------------------------------------------
//  input   | s_tvalid/tready     | center_x[9:0] center_y[19:10] radius[25:20]
//          |                     | fill_color[41:26], zero pad [47:42]
//  output  | m_tvalid/tready     | rect_left[11:0] rect_top[23:12]
//          | m_tlast = last_rect | rect_right[35:24] rect_bottom[47:36] rect_color[63:48]
//
// Sequence: load, setup and the center square, then per one-pixel span a square, the
//   6-step shared isqrt unit and an emit; 1 + 4*(r-k) transfers per command.
//   The isqrt unit sets the rate.
// One command at a time: s_tready is high only while the sequencer is idle.
// Output stalls hold the sequencer in its emit states; the output register lets the
//   next command be accepted while the final rectangle still waits.
// Reset (aresetn low, synchronous) clears the sequencer and m_tvalid.
`default_nettype none

module filled_circle_rect_rasterizer_unit
    import fcr_pkg::*;
#(
    parameter int MAX_RADIUS = 48,
    parameter int COORD_MAX  = 1023
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // center_x[9:0], center_y[19:10], radius[25:20], fill_color[41:26], zero [47:42]
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // rect_left[11:0], rect_top[23:12], rect_right[35:24], rect_bottom[47:36],
    // rect_color[63:48]
    output logic [63:0]      m_tdata,
    output logic             m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SQUARE,
        ST_DSQ,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_EMIT
    } state_t;

    // band order: left columns, top rows, right columns, bottom rows
    localparam logic [1:0] BAND_LEFT   = 2'd0;
    localparam logic [1:0] BAND_TOP    = 2'd1;
    localparam logic [1:0] BAND_RIGHT  = 2'd2;
    localparam logic [1:0] BAND_BOTTOM = 2'd3;

    localparam logic [RAD_W-1:0] RMAX = RAD_W'(MAX_RADIUS);
    localparam logic [15:0]      CMAX = 16'(COORD_MAX);

    state_t               state_reg;
    logic [CX_W-1:0]      cx_reg, cy_reg;
    logic [RAD_W-1:0]     r_reg, k_reg, mag_reg, h_reg;
    logic [SQ_W-1:0]      rsq_reg, dsq_reg;
    logic [COLOR_W-1:0]   color_reg;
    logic [1:0]           band_reg;
    logic                 m_valid_reg, m_last_reg;
    logic [63:0]          m_data_reg;

    // input field unpack and saturation
    logic [CX_W-1:0]      in_cx, in_cy, sat_cx, sat_cy;
    logic [RAD_W-1:0]     in_r, sat_r;
    logic [COLOR_W-1:0]   in_color;

    assign in_cx    = s_tdata[9:0];
    assign in_cy    = s_tdata[19:10];
    assign in_r     = s_tdata[25:20];
    assign in_color = s_tdata[41:26];
    assign sat_cx   = ({6'b0, in_cx} > CMAX) ? CMAX[CX_W-1:0] : in_cx;
    assign sat_cy   = ({6'b0, in_cy} > CMAX) ? CMAX[CX_W-1:0] : in_cy;
    assign sat_r    = (in_r > RMAX) ? RMAX : in_r;

    // setup arithmetic: k = floor(r / sqrt 2), r squared; also the span offset squared
    logic [KPROD_W-1:0]   kprod;
    logic [SQ_W-1:0]      r_sq, mag_sq;

    assign kprod  = KPROD_W'(r_reg) * INV_SQRT2_Q16;
    assign r_sq   = SQ_W'(r_reg) * SQ_W'(r_reg);
    assign mag_sq = SQ_W'(mag_reg) * SQ_W'(mag_reg);

    // shared isqrt unit
    logic                 root_start, root_done;
    logic [SQ_W-1:0]      radicand;
    logic [RAD_W-1:0]     root;

    assign root_start = (state_reg == ST_ROOT_GO);
    assign radicand   = rsq_reg - dsq_reg;

    fcr_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    // rectangle geometry in 12-bit two's complement
    logic [COORD_W-1:0]   cxs, cys, ks, ms, hs;
    logic [COORD_W-1:0]   sq_l, sq_t, sq_r, sq_b;
    logic [COORD_W-1:0]   sp_l, sp_t, sp_r, sp_b;
    logic [RAD_W-1:0]     k_plus1;
    logic                 out_free, out_load, band_end, span_last;

    assign cxs = COORD_W'(cx_reg);
    assign cys = COORD_W'(cy_reg);
    assign ks  = COORD_W'(k_reg);
    assign ms  = COORD_W'(mag_reg);
    assign hs  = COORD_W'(h_reg);

    // center square, left and top edges clamped at 0
    assign sq_l = (cx_reg < CX_W'(k_reg)) ? '0 : cxs - ks;
    assign sq_t = (cy_reg < CX_W'(k_reg)) ? '0 : cys - ks;
    assign sq_r = cxs + ks;
    assign sq_b = cys + ks;

    always_comb begin
        case (band_reg)
            BAND_LEFT: begin
                sp_l = cxs - ms; sp_r = cxs - ms; sp_t = cys - hs; sp_b = cys + hs;
            end
            BAND_TOP: begin
                sp_l = cxs - hs; sp_r = cxs + hs; sp_t = cys - ms; sp_b = cys - ms;
            end
            BAND_RIGHT: begin
                sp_l = cxs + ms; sp_r = cxs + ms; sp_t = cys - hs; sp_b = cys + hs;
            end
            default: begin
                sp_l = cxs - hs; sp_r = cxs + hs; sp_t = cys + ms; sp_b = cys + ms;
            end
        endcase
    end

    assign k_plus1   = k_reg + RAD_W'(1);
    assign out_free  = !m_valid_reg || m_tready;
    // a new rectangle enters the output register this cycle
    assign out_load  = out_free && (state_reg == ST_SQUARE || state_reg == ST_EMIT);
    // left/top walk the offset down from r, right/bottom walk it up to r
    assign band_end  = band_reg[1] ? (mag_reg == r_reg) : (mag_reg == k_plus1);
    assign span_last = (band_reg == BAND_BOTTOM) && band_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cx_reg    <= sat_cx;
                        cy_reg    <= sat_cy;
                        r_reg     <= sat_r;
                        color_reg <= in_color;
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    k_reg     <= kprod[KPROD_W-1:KPROD_W-RAD_W];
                    rsq_reg   <= r_sq;
                    state_reg <= ST_SQUARE;
                end
                ST_SQUARE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_last_reg  <= (r_reg == '0);
                        m_data_reg  <= {color_reg, sq_b, sq_r, sq_t, sq_l};
                        band_reg    <= BAND_LEFT;
                        mag_reg     <= r_reg;
                        state_reg   <= (r_reg == '0) ? ST_IDLE : ST_DSQ;
                    end
                end
                ST_DSQ: begin
                    dsq_reg   <= mag_sq;
                    state_reg <= ST_ROOT_GO;
                end
                ST_ROOT_GO: begin
                    state_reg <= ST_ROOT_WAIT;
                end
                ST_ROOT_WAIT: begin
                    if (root_done) begin
                        h_reg     <= root;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_last_reg  <= span_last;
                        m_data_reg  <= {color_reg, sp_b, sp_r, sp_t, sp_l};
                        if (span_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_DSQ;
                            if (band_end) begin
                                band_reg <= band_reg + 2'd1;
                                mag_reg  <= (band_reg == BAND_LEFT) ? r_reg : k_plus1;
                            end else if (band_reg[1]) begin
                                mag_reg <= mag_reg + RAD_W'(1);
                            end else begin
                                mag_reg <= mag_reg - RAD_W'(1);
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // span offsets stay strictly outside the square and within the radius
    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DSQ || state_reg == ST_EMIT) |->
        (mag_reg > k_reg && mag_reg <= r_reg))
        else $error("span offset out of band range");

    // the root is the floor square root of r^2 - d^2
    a_root_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |->
        ((SQ_W'(h_reg) * SQ_W'(h_reg) <= radicand) &&
         ((SQ_W + 1)'(h_reg + RAD_W'(1)) * (SQ_W + 1)'(h_reg + RAD_W'(1))
          > (SQ_W + 1)'(radicand))))
        else $error("span half-length is not the floor root");

    // the root unit only finishes while the sequencer waits for it
    a_root_done: assert property (@(posedge aclk) disable iff (!aresetn)
        root_done |-> (state_reg == ST_ROOT_WAIT))
        else $error("isqrt finished outside its wait state");

    // a last rectangle loaded into the output always returns the sequencer to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_free && ((state_reg == ST_EMIT && span_last) ||
                      (state_reg == ST_SQUARE && r_reg == '0)))
        |=> (m_tlast && m_tvalid && state_reg == ST_IDLE))
        else $error("last rectangle without return to idle");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_filled_circle_rect_rasterizer_unit.sv
// Testbench for filled_circle_rect_rasterizer_unit: drives circle commands and checks
// every rectangle against an in-bench disc-cover predictor. Depends on fcr_pkg and the RTL.
module tb_filled_circle_rect_rasterizer_unit;
    import fcr_pkg::*;

    localparam int MAX_R      = 48;
    localparam int CMAX       = 1023;
    localparam int Q16_HALF   = 46341;      // 1/sqrt(2) in Q0.16, rounded
    localparam int TAIL_WAIT  = 800;        // longer than the largest command
    localparam int CYCLE_LIMIT = 2_000_000;

    // One expected output rectangle.
    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
        logic [COLOR_W-1:0] color;
        logic               last;
    } rect_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // center_x[9:0], center_y[19:10], radius[25:20], fill_color[41:26], zero [47:42]
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // rect_left[11:0], rect_top[23:12], rect_right[35:24], rect_bottom[47:36],
    // rect_color[63:48]
    logic [63:0] m_tdata;
    logic        m_tlast;

    rect_t       rect_q[$];         // rectangles still owed by the DUT, oldest first
    int          src_idle_pct  = 0; // chance per cycle the sender holds off
    int          sink_idle_pct = 0; // chance per cycle the receiver stalls
    int          err_cnt       = 0;
    int          cmd_cnt       = 0;
    int          rect_cnt      = 0;
    int          sat_cnt       = 0;
    int unsigned cycle_cnt     = 0;

    filled_circle_rect_rasterizer_unit #(
        .MAX_RADIUS (MAX_R),
        .COORD_MAX  (CMAX)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver back-pressure, changed on the falling edge only.
    always @(negedge aclk) begin
        if (aresetn)
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Largest h with h*h <= v.
    function automatic int span_half(int v);
        int h;
        h = 0;
        while ((h + 1) * (h + 1) <= v)
            h++;
        return h;
    endfunction

    // Coordinates wrap to 12-bit two's complement, as on the bus.
    function automatic void add_rect(int l, int t, int r, int b, logic [COLOR_W-1:0] c);
        rect_t e;
        e.left   = COORD_W'(l);
        e.top    = COORD_W'(t);
        e.right  = COORD_W'(r);
        e.bottom = COORD_W'(b);
        e.color  = c;
        e.last   = 1'b0;
        rect_q.push_back(e);
    endfunction

    // Expected rectangles for one circle: center square, then left, top, right and
    // bottom one-pixel bands, each band ordered by its offset.
    function automatic void predict_circle(logic [CX_W-1:0] cx_in, logic [CX_W-1:0] cy_in,
                                           logic [RAD_W-1:0] r_in, logic [COLOR_W-1:0] c);
        int cx, cy, r, k, d, h, l, t;
        cx = (cx_in > CMAX) ? CMAX : int'(cx_in);
        cy = (cy_in > CMAX) ? CMAX : int'(cy_in);
        r  = (r_in > MAX_R) ? MAX_R : int'(r_in);
        k  = (r * Q16_HALF) >>> 16;
        // only the left and top edges of the center square are clamped
        l  = (cx - k < 0) ? 0 : cx - k;
        t  = (cy - k < 0) ? 0 : cy - k;
        add_rect(l, t, cx + k, cy + k, c);
        for (int band = 0; band < 4; band++) begin
            for (int i = 0; i < r - k; i++) begin
                // bands 0,1 run -r .. -(k+1); bands 2,3 run k+1 .. r
                d = (band < 2) ? -r + i : k + 1 + i;
                h = span_half(r * r - d * d);
                if (band % 2 == 0)
                    add_rect(cx + d, cy - h, cx + d, cy + h, c);  // column
                else
                    add_rect(cx - h, cy + d, cx + h, cy + d, c);  // row
            end
        end
        rect_q[rect_q.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every output transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : rect_check
        rect_t       e;
        logic [15:0] want[6];
        logic [15:0] got[6];
        string       fname[6];
        if (aresetn && m_tvalid && m_tready) begin
            if (rect_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected rectangle tdata=%h tlast=%b",
                         $time, m_tdata, m_tlast);
            end else begin
                e = rect_q.pop_front();
                rect_cnt++;
                fname = '{"rect_left", "rect_top", "rect_right", "rect_bottom",
                          "rect_color", "last_rect"};
                want  = '{16'(e.left), 16'(e.top), 16'(e.right), 16'(e.bottom),
                          e.color, 16'(e.last)};
                got   = '{16'(m_tdata[11:0]), 16'(m_tdata[23:12]), 16'(m_tdata[35:24]),
                          16'(m_tdata[47:36]), m_tdata[63:48], 16'(m_tlast)};
                for (int f = 0; f < 6; f++) begin
                    if (want[f] !== got[f]) begin
                        err_cnt++;
                        $display("%0t: %s mismatch, expected %h, actual %h",
                                 $time, fname[f], want[f], got[f]);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one circle command; expectations are queued at the accepting edge.
    task automatic send_circle(input logic [CX_W-1:0] cx, input logic [CX_W-1:0] cy,
                               input logic [RAD_W-1:0] r, input logic [COLOR_W-1:0] c);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, c, r, cy, cx};
        do
            @(posedge aclk);
        while (!s_tready);
        predict_circle(cx, cy, r, c);
        cmd_cnt++;
        if (r > MAX_R)
            sat_cnt++;
    endtask

    // Drop valid and hold off until every owed rectangle has been seen.
    task automatic wait_rects_done();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (rect_q.size() != 0)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero and tiny radii: single square, then the first bands appearing.
    task automatic test_small_radii();
        send_circle(10'd500, 10'd500, 6'd0, 16'h0000);
        send_circle(10'd500, 10'd500, 6'd1, 16'hFFFF);
        send_circle(10'd200, 10'd300, 6'd2, 16'hF800);
        send_circle(10'd777, 10'd123, 6'd3, 16'h07E0);
        send_circle(10'd321, 10'd654, 6'd7, 16'h001F);
    endtask

    // Radius below, at and above the limit, including all-ones.
    task automatic test_radius_saturation();
        send_circle(10'd512, 10'd512, 6'd48, 16'hA5A5);
        send_circle(10'd512, 10'd512, 6'd49, 16'h5A5A);
        send_circle(10'd100, 10'd900, 6'd63, 16'hFFFF);
        send_circle(10'd900, 10'd100, 6'd47, 16'h0001);
    endtask

    // Centers on and near the screen corners: clamped square edges, negative and
    // over-range band coordinates.
    task automatic test_edge_centers();
        send_circle(10'd0,    10'd0,    6'd48, 16'h1234);
        send_circle(10'd1023, 10'd1023, 6'd48, 16'h8000);
        send_circle(10'd0,    10'd1023, 6'd20, 16'h7FFF);
        send_circle(10'd1023, 10'd0,    6'd63, 16'hC3C3);
        send_circle(10'd5,    10'd3,    6'd10, 16'h0F0F);
        send_circle(10'd0,    10'd0,    6'd0,  16'hFFFF);
    endtask

    // Random circles, mostly small radii and some near the screen edges.
    task automatic test_random_circles(input int n, input int src_pct, input int sink_pct);
        logic [CX_W-1:0]    cx, cy;
        logic [RAD_W-1:0]   r;
        logic [COLOR_W-1:0] c;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int i = 0; i < n; i++) begin
            r  = ($urandom_range(9) < 7) ? RAD_W'($urandom_range(20))
                                         : RAD_W'($urandom_range(63, 21));
            cx = ($urandom_range(7) == 0) ? CX_W'($urandom_range(1) ? $urandom_range(40)
                                                 : $urandom_range(1023, 983))
                                          : CX_W'($urandom_range(1023));
            cy = ($urandom_range(7) == 0) ? CX_W'($urandom_range(1) ? $urandom_range(40)
                                                 : $urandom_range(1023, 983))
                                          : CX_W'($urandom_range(1023));
            c  = COLOR_W'($urandom);
            send_circle(cx, cy, r, c);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, sender and receiver both busy-ish
        src_idle_pct  = 10;
        sink_idle_pct = 59;
        test_small_radii();
        test_radius_saturation();
        test_edge_centers();
        wait_rects_done();

        test_random_circles(95, 10, 59);
        wait_rects_done();   // sender holds off until the DUT is drained
        test_random_circles(95, 59, 10);
        wait_rects_done();
        test_random_circles(95, 0, 0);

        // tail: drain, then watch for stray transfers
        wait_rects_done();
        repeat (TAIL_WAIT) @(posedge aclk);

        $display("Ran %0d circle commands (%0d with radius over the limit), %0d rectangles",
                 cmd_cnt, sat_cnt, rect_cnt);
        $display("checked across three idle mixes, %0d mismatches", err_cnt);
        if (err_cnt == 0 && rect_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
